// ===== hw/rtl/smpq_pkg.sv =====
// package for the sorted minimum priority queue
// holds field widths, action and status codes, and the control/status structs
// no dependencies
package smpq_pkg;

	// default sizes handed to the top-level parameters
	localparam int DEPTH_DEF     = 16;
	localparam int KEY_WIDTH_DEF = 16;

	// fixed field widths of the channels
	localparam int ACTION_W = 2;
	localparam int ITEM_W   = 16;
	localparam int STATUS_W = 2;
	localparam int OCC_W    = 5;

	// action codes
	localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_PEEK   = 2'd2;

	// status codes
	localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

	// commands from the controller to the datapath
	typedef struct packed {
		logic accept;     // latch the new item, start the head read
		logic shift_step; // move the entry below the insert point up one slot
		logic place;      // write the new entry at the insert point
		logic commit;     // load the result register, update the count
	} smpq_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic ins_ok;   // incoming item is an insert and the queue has room
		logic pos_zero; // insert point reached the bottom slot
		logic rd_less;  // entry read below the insert point has a smaller key
	} smpq_stat_t;

endpackage

// ===== hw/rtl/smpq_ifs.sv =====
// request and response channel interfaces of the priority queue
// depends on smpq_pkg for field widths
interface smpq_req_if;
	import smpq_pkg::*;

	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [ITEM_W-1:0]   item_key;
	logic [ITEM_W-1:0]   item_tag;

	modport source (output valid, action, item_key, item_tag, input ready);
	modport sink   (input valid, action, item_key, item_tag, output ready);
endinterface

interface smpq_rsp_if;
	import smpq_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [ITEM_W-1:0]   head_key;
	logic [ITEM_W-1:0]   head_tag;
	logic [OCC_W-1:0]    occupancy;

	modport source (output valid, status, head_key, head_tag, occupancy, input ready);
	modport sink   (input valid, status, head_key, head_tag, occupancy, output ready);
endinterface

// ===== hw/rtl/smpq_ctrl.sv =====
// controller state machine of the priority queue
// sequences accept, insert shifting and result commit; depends on smpq_pkg
module smpq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  smpq_pkg::smpq_stat_t stat,
	output smpq_pkg::smpq_cmd_t  cmd
);
	import smpq_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SHIFT  = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

	state_t state_q, state_nx;
	logic   out_valid_q;
	logic   out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	// next state and commands
	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_nx   = stat.ins_ok ? ST_SHIFT : ST_FINISH;
				end
			end
			ST_SHIFT: begin
				if (stat.pos_zero || !stat.rd_less) begin
					cmd.place = 1'b1;
					state_nx  = ST_FINISH;
				end else begin
					cmd.shift_step = 1'b1;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					cmd.commit = 1'b1;
					state_nx   = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// state and output valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== hw/rtl/smpq_dp.sv =====
// datapath of the priority queue: entry memory, insert pointer, count, result
// register; driven by smpq_ctrl commands, depends on smpq_pkg
module smpq_dp #(
	parameter int DEPTH     = smpq_pkg::DEPTH_DEF,
	parameter int KEY_WIDTH = smpq_pkg::KEY_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  smpq_pkg::smpq_cmd_t            cmd,
	output smpq_pkg::smpq_stat_t           stat,
	input  logic [smpq_pkg::ACTION_W-1:0]  action,
	input  logic [smpq_pkg::ITEM_W-1:0]    item_key,
	input  logic [smpq_pkg::ITEM_W-1:0]    item_tag,
	output logic [smpq_pkg::STATUS_W-1:0]  status,
	output logic [smpq_pkg::ITEM_W-1:0]    head_key,
	output logic [smpq_pkg::ITEM_W-1:0]    head_tag,
	output logic [smpq_pkg::OCC_W-1:0]     occupancy
);
	import smpq_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	// entry memory, slot count-1 is the head
	logic [KEY_WIDTH-1:0] key_mem [DEPTH];
	logic [ITEM_W-1:0]    tag_mem [DEPTH];

	logic [ACTION_W-1:0]  act_q;
	logic [KEY_WIDTH-1:0] key_q;
	logic [ITEM_W-1:0]    tag_q;
	logic [AW-1:0]        pos_q;
	logic [CW-1:0]        count_q;
	logic [KEY_WIDTH-1:0] rd_key_q;
	logic [ITEM_W-1:0]    rd_tag_q;

	logic [AW-1:0]        rd_addr;
	logic                 rd_en;
	logic [KEY_WIDTH-1:0] wr_key;
	logic [ITEM_W-1:0]    wr_tag;
	logic                 full;
	logic                 empty;

	logic [STATUS_W-1:0]  res_status;
	logic [ITEM_W-1:0]    res_key;
	logic [ITEM_W-1:0]    res_tag;
	logic [CW-1:0]        count_nx;

	logic [STATUS_W-1:0]  status_q;
	logic [ITEM_W-1:0]    head_key_q;
	logic [ITEM_W-1:0]    head_tag_q;
	logic [OCC_W-1:0]     occ_q;

	assign full  = (count_q >= CW'(DEPTH));
	assign empty = (count_q == '0);

	// status toward the controller
	assign stat.ins_ok   = (action == ACT_INSERT) && !full;
	assign stat.pos_zero = (pos_q == '0);
	assign stat.rd_less  = (rd_key_q < key_q);

	// read the head at accept, the slot below the next insert point while shifting
	assign rd_en   = cmd.accept || cmd.shift_step;
	assign rd_addr = cmd.accept ? AW'(count_q - CW'(1)) : (pos_q - AW'(2));

	// write data: either the entry moving up or the new entry
	assign wr_key = cmd.place ? key_q : rd_key_q;
	assign wr_tag = cmd.place ? tag_q : rd_tag_q;

	// entry memory write and registered read
	always_ff @(posedge clk) begin
		if (cmd.shift_step || cmd.place) begin
			key_mem[pos_q] <= wr_key;
			tag_mem[pos_q] <= wr_tag;
		end
		if (rd_en) begin
			rd_key_q <= key_mem[rd_addr];
			rd_tag_q <= tag_mem[rd_addr];
		end
	end

	// item and insert pointer registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			act_q <= action;
			key_q <= KEY_WIDTH'(item_key);
			tag_q <= item_tag;
			pos_q <= AW'(count_q);
		end else if (cmd.shift_step) begin
			pos_q <= pos_q - AW'(1);
		end
	end

	// result and next count for the held item
	always_comb begin
		res_status = STAT_OK;
		res_key    = '0;
		res_tag    = '0;
		count_nx   = count_q;
		case (act_q)
			ACT_INSERT: begin
				if (full) begin
					res_status = STAT_FULL;
				end else begin
					count_nx = count_q + CW'(1);
				end
			end
			ACT_REMOVE, ACT_PEEK: begin
				if (empty) begin
					res_status = STAT_EMPTY;
				end else begin
					res_key = ITEM_W'(rd_key_q);
					res_tag = rd_tag_q;
					if (act_q == ACT_REMOVE) begin
						count_nx = count_q - CW'(1);
					end
				end
			end
			default: begin
			end
		endcase
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.commit) begin
			count_q <= count_nx;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status_q   <= res_status;
			head_key_q <= res_key;
			head_tag_q <= res_tag;
			occ_q      <= OCC_W'(count_nx);
		end
	end

	assign status    = status_q;
	assign head_key  = head_key_q;
	assign head_tag  = head_tag_q;
	assign occupancy = occ_q;

endmodule

// ===== hw/rtl/sorted_min_priority_queue_unit.sv =====
// Bounded minimum priority queue kept as a sorted array of DEPTH (key, tag) entries.
// Each request inserts an entry, removes the head or peeks at it, and each gives
// one response with a status, the head key and tag (remove and peek) and the
// occupancy after the request. The head is the smallest key; among equal keys
// the newest entry leaves first. An insert into a full queue answers full, a
// remove or peek on an empty queue answers empty, and an unused action code
// changes nothing. Remove, peek, refused inserts and unused codes go from
// accept straight to the result; an insert first moves each stored entry with a
// smaller key up one slot, as the entry memory (one read and one write port)
// compares and moves one entry per cycle.
// A new request is taken while the previous response waits in the output
// register. Keys are stored as the low KEY_WIDTH bits of item_key.
// Depends on smpq_pkg, smpq_ifs, smpq_ctrl and smpq_dp.
module sorted_min_priority_queue_unit #(
	parameter int DEPTH     = smpq_pkg::DEPTH_DEF,
	parameter int KEY_WIDTH = smpq_pkg::KEY_WIDTH_DEF
) (
	input logic        clk,
	input logic        arst_n,
	smpq_req_if.sink   req,
	smpq_rsp_if.source rsp
);
	import smpq_pkg::*;

	smpq_cmd_t  cmd;
	smpq_stat_t stat;

	// sequencing
	smpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// storage and result
	smpq_dp #(
		.DEPTH     (DEPTH),
		.KEY_WIDTH (KEY_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.action    (req.action),
		.item_key  (req.item_key),
		.item_tag  (req.item_tag),
		.status    (rsp.status),
		.head_key  (rsp.head_key),
		.head_tag  (rsp.head_tag),
		.occupancy (rsp.occupancy)
	);

endmodule

// ===== test/tb_top.sv =====
// self-checking bench for sorted_min_priority_queue_unit: request/response traffic
// with random stalls, a shadow sorted queue predicts every response
// depends on smpq_pkg, smpq_ifs and the rtl of the unit
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import smpq_pkg::*;

	localparam int                      Q_DEPTH    = DEPTH_DEF;
	localparam logic [ITEM_W-1:0]       KEY_MASK   = ITEM_W'((64'd1 << KEY_WIDTH_DEF) - 1);
	localparam logic [ACTION_W-1:0]     ACT_UNUSED = 2'd3;
	localparam int                      NUM_ITEMS  = 1550;
	localparam int                      CALM_FROM  = 1350;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ITEM_W-1:0]   head_key;
		logic [ITEM_W-1:0]   head_tag;
		logic [OCC_W-1:0]    occupancy;
	} pq_resp_t;

	// shadow copy of the sorted queue and the responses still owed by the unit
	class pq_shadow;
		logic [ITEM_W-1:0] key_slot[Q_DEPTH];
		logic [ITEM_W-1:0] tag_slot[Q_DEPTH];
		int unsigned       fill;
		pq_resp_t          pending_resp[$];
		int unsigned       mismatch_cnt;

		function new();
			fill         = 0;
			mismatch_cnt = 0;
		endfunction

		// work out the response of one accepted request and update the shadow
		function void note_request(logic [ACTION_W-1:0] act, logic [ITEM_W-1:0] k,
				logic [ITEM_W-1:0] t);
			pq_resp_t          r;
			int unsigned       pos;
			logic [ITEM_W-1:0] kk;
			r        = '0;
			r.status = STAT_OK;
			kk       = k & KEY_MASK;
			case (act)
				ACT_INSERT: begin
					if (fill >= Q_DEPTH) begin
						r.status = STAT_FULL;
					end else begin
						// smaller keys move toward the head, equal keys stay behind the new one
						pos = fill;
						while (pos > 0 && key_slot[pos-1] < kk) begin
							key_slot[pos] = key_slot[pos-1];
							tag_slot[pos] = tag_slot[pos-1];
							pos--;
						end
						key_slot[pos] = kk;
						tag_slot[pos] = t;
						fill++;
					end
				end
				ACT_REMOVE, ACT_PEEK: begin
					if (fill == 0) begin
						r.status = STAT_EMPTY;
					end else begin
						r.head_key = key_slot[fill-1];
						r.head_tag = tag_slot[fill-1];
						if (act == ACT_REMOVE)
							fill--;
					end
				end
				default: ;
			endcase
			r.occupancy = fill[OCC_W-1:0];
			pending_resp.push_back(r);
		endfunction

		task report_mismatch(string what);
			if (mismatch_cnt < 40)
				$display("mismatch at %0t ns: %s", $time, what);
			mismatch_cnt++;
		endtask

		// compare one response transfer with the oldest prediction
		task check_response(pq_resp_t got);
			pq_resp_t want;
			if (pending_resp.size() == 0) begin
				report_mismatch("response with nothing outstanding");
			end else begin
				want = pending_resp.pop_front();
				if (got.status !== want.status)
					report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
				if (got.head_key !== want.head_key)
					report_mismatch($sformatf("head_key %h, want %h", got.head_key,
						want.head_key));
				if (got.head_tag !== want.head_tag)
					report_mismatch($sformatf("head_tag %h, want %h", got.head_tag,
						want.head_tag));
				if (got.occupancy !== want.occupancy)
					report_mismatch($sformatf("occupancy %0d, want %0d", got.occupancy,
						want.occupancy));
			end
		endtask
	endclass

	logic     clk;
	logic     arst_n;
	bit       no_idle;
	pq_shadow sb;

	smpq_req_if req_ch();
	smpq_rsp_if rsp_ch();

	sorted_min_priority_queue_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch.sink),
		.rsp    (rsp_ch.source)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// drive one request and hold it until the transfer
	task automatic send_request(logic [ACTION_W-1:0] act, logic [ITEM_W-1:0] k,
			logic [ITEM_W-1:0] t);
		req_ch.valid    <= 1'b1;
		req_ch.action   <= act;
		req_ch.item_key <= k;
		req_ch.item_tag <= t;
		do @(posedge clk); while (!req_ch.ready);
		sb.note_request(act, k, t);
	endtask

	task automatic hold_sender(int unsigned cycles);
		req_ch.valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// keys lean toward extremes and a narrow range so equal keys are common
	function automatic logic [ITEM_W-1:0] pick_key();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2, 3, 4: return ITEM_W'($urandom_range(0, 7));
			5:       return ITEM_W'($urandom_range(16'hfff8, 16'hffff));
			default: return ITEM_W'($urandom);
		endcase
	endfunction

	function automatic logic [ITEM_W-1:0] pick_tag();
		case ($urandom_range(0, 15))
			0:       return '0;
			1:       return '1;
			default: return ITEM_W'($urandom);
		endcase
	endfunction

	// response side: check every transfer, stall ready in short bursts
	initial begin
		int unsigned stall_left;
		stall_left   = 0;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready)
				sb.check_response('{rsp_ch.status, rsp_ch.head_key, rsp_ch.head_tag,
					rsp_ch.occupancy});
			if (stall_left > 0 && !no_idle) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 9) == 0) begin
				stall_left   = $urandom_range(1, 4) - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// request side: reset, directed cases, random phases, drain
	initial begin
		int unsigned      sent;
		int unsigned      phase_no;
		int unsigned      phase_len;
		int unsigned      ins_pct;
		int unsigned      r;
		logic [ACTION_W-1:0] act;
		sb              = new();
		no_idle         = 1'b0;
		arst_n          <= 1'b0;
		req_ch.valid    <= 1'b0;
		req_ch.action   <= ACT_INSERT;
		req_ch.item_key <= '0;
		req_ch.item_tag <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queue: peek, remove and an unused code
		send_request(ACT_PEEK, 16'h5a5a, 16'ha5a5);
		send_request(ACT_REMOVE, '1, '1);
		send_request(ACT_UNUSED, '1, '1);
		// extreme keys, then equal keys where the newer one must come out first
		send_request(ACT_INSERT, '1, '1);
		send_request(ACT_INSERT, '0, '0);
		send_request(ACT_INSERT, 16'h1234, 16'h000a);
		send_request(ACT_INSERT, 16'h1234, 16'h000b);
		send_request(ACT_PEEK, '0, '0);
		send_request(ACT_REMOVE, '0, '0);
		send_request(ACT_PEEK, '0, '0);
		// fill up, then an insert that is refused and an unused code on a full queue
		for (int i = 0; i < Q_DEPTH - 3; i++)
			send_request(ACT_INSERT, (i % 3 == 0) ? 16'h1234 : pick_key(),
				ITEM_W'(16'h0100 + i));
		send_request(ACT_INSERT, '0, 16'hdead);
		send_request(ACT_UNUSED, 16'h0000, 16'h0000);
		send_request(ACT_REMOVE, '0, '0);
		send_request(ACT_PEEK, '0, '0);
		sent = 10 + Q_DEPTH - 3 + 4;

		// random phases with varying insert pressure
		phase_no = 0;
		while (sent < NUM_ITEMS) begin
			case ($urandom_range(0, 3))
				0:       ins_pct = 85;
				1:       ins_pct = 20;
				2:       ins_pct = 50;
				default: ins_pct = 97;
			endcase
			phase_len = $urandom_range(40, 120);
			for (int n = 0; n < phase_len && sent < NUM_ITEMS; n++) begin
				r = $urandom_range(0, 99);
				if (r < 3)
					act = ACT_UNUSED;
				else if (r < 3 + ins_pct)
					act = ACT_INSERT;
				else
					act = ($urandom_range(0, 2) == 0) ? ACT_PEEK : ACT_REMOVE;
				send_request(act, pick_key(), pick_tag());
				sent++;
				if (sent >= CALM_FROM)
					no_idle = 1'b1;
				if (!no_idle && $urandom_range(0, 7) == 0)
					hold_sender($urandom_range(1, 4));
			end
			// every few phases let the unit run dry before going on
			if (phase_no % 4 == 0 && !no_idle) begin
				req_ch.valid <= 1'b0;
				do @(posedge clk); while (sb.pending_resp.size() != 0);
			end
			phase_no++;
		end

		// wait for the last responses, then keep running to catch strays
		req_ch.valid <= 1'b0;
		while (sb.pending_resp.size() != 0) @(posedge clk);
		repeat (Q_DEPTH + 8) @(posedge clk);
		if (sb.mismatch_cnt == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/smpq_pkg.sv
hw/rtl/smpq_ifs.sv
hw/rtl/smpq_ctrl.sv
hw/rtl/smpq_dp.sv
hw/rtl/sorted_min_priority_queue_unit.sv
test/tb_top.sv
